// ===== rtl/video_wall_tile_layout_core_assert.svh =====
// ----------------------------------------------------------------------------
// Video wall tile layout: assertion macros
// Shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef VIDEO_WALL_TILE_LAYOUT_CORE_ASSERT_SVH
`define VIDEO_WALL_TILE_LAYOUT_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define VWTL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vwtl check failed");

// next-cycle implication, off during reset
`define VWTL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vwtl check failed");

// next-cycle implication, live through reset
`define VWTL_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("vwtl reset check failed");

`endif

// ===== rtl/vwtl_pkg.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout: shared package
// Types, register indexes, reset values and divide-by-constant helpers.
// ----------------------------------------------------------------------------
package vwtl_pkg;

   localparam int STREAM_CAP = 16;
   localparam int LANES      = 4;
   localparam int PROD_W     = 21;
   localparam int QUOT_W     = 15;
   localparam int RCP_W      = 27;
   localparam int RCP_SHIFT  = 27;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_CUSTOM_MODE  = 3'd2;
   localparam logic [2:0] CSR_TILE_COUNT   = 3'd3;
   localparam logic [2:0] CSR_SPACING_H    = 3'd4;
   localparam logic [2:0] CSR_SPACING_V    = 3'd5;

   localparam logic [13:0] RESET_FRAME_WIDTH  = 14'd1920;
   localparam logic [13:0] RESET_FRAME_HEIGHT = 14'd1080;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_COMPOSE = 1'b1;

   typedef struct packed {
      logic [13:0] frame_width;
      logic [13:0] frame_height;
      logic        custom_mode;
      logic [4:0]  tile_count;
      logic [9:0]  spacing_h;
      logic [9:0]  spacing_v;
   } cfg_type;

   // bit layout of one tile table entry, left percent in the low bits
   typedef struct packed {
      logic [3:0] grid_col;
      logic [3:0] grid_row;
      logic [6:0] height_pct;
      logic [6:0] width_pct;
      logic [6:0] top_pct;
      logic [6:0] left_pct;
   } tile_type;

   typedef struct packed {
      logic       is_load;
      logic [4:0] stream_count;
      logic [3:0] tile_slot;
      tile_type   tile;
   } job_type;

   typedef enum logic [1:0] {
      DIV_PCT,
      DIV_2,
      DIV_3,
      DIV_4
   } div_code_type;

   function automatic logic [6:0] div_value(div_code_type code);
      logic [6:0] val;
      unique case (code)
         DIV_PCT: val = 7'd100;
         DIV_2:   val = 7'd2;
         DIV_3:   val = 7'd3;
         DIV_4:   val = 7'd4;
         default: val = 7'd100;
      endcase
      return val;
   endfunction

   // floor(2^27 / divisor); quotient comes out exact or one short
   function automatic logic [RCP_W-1:0] div_recip(div_code_type code);
      logic [RCP_W-1:0] val;
      unique case (code)
         DIV_PCT: val = RCP_W'((1 << RCP_SHIFT) / 100);
         DIV_2:   val = RCP_W'((1 << RCP_SHIFT) / 2);
         DIV_3:   val = RCP_W'((1 << RCP_SHIFT) / 3);
         DIV_4:   val = RCP_W'((1 << RCP_SHIFT) / 4);
         default: val = RCP_W'((1 << RCP_SHIFT) / 100);
      endcase
      return val;
   endfunction

   // grid rows for five or more streams, as a divisor
   function automatic div_code_type rows_code(logic [4:0] n);
      div_code_type code;
      if (n <= 5'd6) begin
         code = DIV_2;
      end else if (n <= 5'd12) begin
         code = DIV_3;
      end else begin
         code = DIV_4;
      end
      return code;
   endfunction

endpackage

// ===== rtl/vwtl_ram.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vwtl_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/vwtl_front.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout: front end
// Accepts items, drops the ones that do nothing, queues the rest in order.
// ----------------------------------------------------------------------------
module vwtl_front #(
   parameter int MAX_STREAMS = 16,
   parameter int MAX_TILES   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_cmd,
   input  logic [4:0]       req_stream_count,
   input  logic [3:0]       req_tile_slot,
   input  logic [6:0]       req_left_pct,
   input  logic [6:0]       req_top_pct,
   input  logic [6:0]       req_width_pct,
   input  logic [6:0]       req_height_pct,
   input  logic [3:0]       req_grid_row,
   input  logic [3:0]       req_grid_col,
   output logic             job_valid,
   output vwtl_pkg::job_type job_head,
   input  logic             job_pop
);
   import vwtl_pkg::*;

   localparam int NMAX = (MAX_STREAMS < STREAM_CAP) ? MAX_STREAMS : STREAM_CAP;

   job_type    entry_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic       accept;
   logic       push;
   logic [4:0] n_sat;
   logic       slot_ok;
   job_type    job_new;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   assign n_sat   = (req_stream_count > 5'(NMAX)) ? 5'(NMAX) : req_stream_count;
   assign slot_ok = ({28'd0, req_tile_slot} < 32'(MAX_TILES));

   always_comb begin
      job_new.is_load         = (req_cmd == CMD_LOAD);
      job_new.stream_count    = n_sat;
      job_new.tile_slot       = req_tile_slot;
      job_new.tile.left_pct   = req_left_pct;
      job_new.tile.top_pct    = req_top_pct;
      job_new.tile.width_pct  = req_width_pct;
      job_new.tile.height_pct = req_height_pct;
      job_new.tile.grid_row   = req_grid_row;
      job_new.tile.grid_col   = req_grid_col;
   end

   // drop loads to missing slots and empty compose requests
   assign push = accept && (job_new.is_load ? slot_ok : (n_sat != 5'd0));

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_new;
      end
   end

   assign job_valid = (count_ff != 2'd0);
   assign job_head  = entry_ff[rd_ptr_ff];

endmodule

// ===== rtl/vwtl_back.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout: back end
// Runs queued jobs: writes tile slots and walks compose requests one
// rectangle at a time through a four-lane divide-by-constant pipeline.
// ----------------------------------------------------------------------------
module vwtl_back #(
   parameter int MAX_TILES  = 16,
   parameter int TILE_DEPTH = 16,
   localparam int TILE_AW = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vwtl_pkg::cfg_type    cfg,
   input  logic                 job_valid,
   input  vwtl_pkg::job_type    job_head,
   output logic                 job_pop,
   output logic                 ram_we,
   output logic [TILE_AW-1:0]   ram_waddr,
   output logic [35:0]          ram_wdata,
   output logic [TILE_AW-1:0]   ram_raddr,
   input  logic [35:0]          ram_rdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_rect_index,
   output logic [15:0]          rsp_rect_left,
   output logic [15:0]          rsp_rect_top,
   output logic [15:0]          rsp_rect_width,
   output logic [15:0]          rsp_rect_height,
   output logic                 rsp_placed,
   output logic                 rsp_last
);
   import vwtl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_RCP,
      ST_FIX,
      ST_OUT
   } state_type;

   state_type    state_ff, state_in;
   logic [4:0]   n_ff, n_in;
   logic         custom_ff, custom_in;
   logic [4:0]   tcount_ff, tcount_in;
   div_code_type cols_ff, cols_in;
   div_code_type rows_ff, rows_in;
   logic [1:0]   col_ctr_ff, col_ctr_in;
   logic [1:0]   row_ctr_ff, row_ctr_in;
   logic [3:0]   idx_ff, idx_in;
   logic [3:0]   tile_row_ff, tile_row_in;
   logic [3:0]   tile_col_ff, tile_col_in;
   logic         placed_ff, placed_in;

   logic [PROD_W-1:0] prod_ff [0:LANES-1];
   logic [PROD_W-1:0] prod_in [0:LANES-1];
   div_code_type      code_ff [0:LANES-1];
   div_code_type      code_in [0:LANES-1];
   logic [QUOT_W-1:0] q0_ff   [0:LANES-1];
   logic [QUOT_W-1:0] q0_in   [0:LANES-1];
   logic [QUOT_W-1:0] q_ff    [0:LANES-1];
   logic [QUOT_W-1:0] q_in    [0:LANES-1];
   logic [QUOT_W-1:0] q0_calc [0:LANES-1];
   logic [QUOT_W-1:0] q_calc  [0:LANES-1];
   logic [PROD_W-1:0] rem_calc [0:LANES-1];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic [15:0] rsp_left_ff, rsp_left_in;
   logic [15:0] rsp_top_ff, rsp_top_in;
   logic [15:0] rsp_width_ff, rsp_width_in;
   logic [15:0] rsp_height_ff, rsp_height_in;
   logic        rsp_placed_ff, rsp_placed_in;
   logic        rsp_last_ff, rsp_last_in;

   tile_type    tile_rd;
   logic        out_free;
   logic        is_last;
   logic        spacing_any;
   logic [4:0]  tcount_sat;
   logic [12:0] cw;
   logic [12:0] ch;
   logic [15:0] r_left, r_top, r_width, r_height;

   assign tile_rd     = tile_type'(ram_rdata);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign is_last     = ({1'b0, idx_ff} + 5'd1 == n_ff);
   assign spacing_any = (cfg.spacing_h != 10'd0) || (cfg.spacing_v != 10'd0);
   assign tcount_sat  = ({2'b00, cfg.tile_count} > 7'(MAX_TILES)) ?
                        5'(MAX_TILES) : cfg.tile_count;

   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign ram_we    = job_pop && job_head.is_load;
   assign ram_waddr = job_head.tile_slot[TILE_AW-1:0];
   assign ram_wdata = job_head.tile;
   assign ram_raddr = idx_ff[TILE_AW-1:0];

   // divide by constant: reciprocal multiply, then one correction step
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign q0_calc[k]  = QUOT_W'((48'(prod_ff[k]) * 48'(div_recip(code_ff[k])))
                                   >> RCP_SHIFT);
      assign rem_calc[k] = prod_ff[k] -
                           PROD_W'(22'(q0_ff[k]) * 22'(div_value(code_ff[k])));
      assign q_calc[k]   = q0_ff[k] +
                           QUOT_W'(rem_calc[k] >= PROD_W'(div_value(code_ff[k])));
   end

   // half-frame cells for the two to four stream layouts
   assign cw = (cfg.frame_width[13:1] > 13'd1) ? cfg.frame_width[13:1] - 13'd1 : 13'd0;
   assign ch = (cfg.frame_height[13:1] > 13'd1) ? cfg.frame_height[13:1] - 13'd1 : 13'd0;

   // rectangle of the current stream
   always_comb begin
      r_left   = 16'd0;
      r_top    = 16'd0;
      r_width  = 16'd0;
      r_height = 16'd0;
      if (custom_ff) begin
         if (placed_ff) begin
            r_left   = 16'(q_ff[0]) + 16'(14'(tile_col_ff) * 14'(cfg.spacing_h));
            r_top    = 16'(q_ff[1]) + 16'(14'(tile_row_ff) * 14'(cfg.spacing_v));
            r_width  = 16'(q_ff[2]);
            r_height = 16'(q_ff[3]);
            if (spacing_any) begin
               r_width  = (q_ff[2] > QUOT_W'(cfg.spacing_h)) ?
                          16'(q_ff[2] - QUOT_W'(cfg.spacing_h)) : 16'd1;
               r_height = (q_ff[3] > QUOT_W'(cfg.spacing_v)) ?
                          16'(q_ff[3] - QUOT_W'(cfg.spacing_v)) : 16'd1;
            end
         end
      end else if (n_ff == 5'd1) begin
         r_width  = 16'(cfg.frame_width);
         r_height = 16'(cfg.frame_height);
      end else if (n_ff <= 5'd4) begin
         r_width  = 16'(cw);
         r_height = 16'(ch);
         case (idx_ff)
            4'd0: begin
               r_left = 16'd0;
               r_top  = (n_ff == 5'd2) ? 16'(ch[12:1]) : 16'd0;
            end
            4'd1: begin
               r_left = 16'(cw);
               r_top  = (n_ff == 5'd2) ? 16'(ch[12:1]) : 16'd0;
            end
            4'd2: begin
               r_left = (n_ff == 5'd3) ? 16'(cw[12:1]) : 16'd0;
               r_top  = 16'(ch);
            end
            default: begin
               r_left = 16'(cw);
               r_top  = 16'(ch);
            end
         endcase
      end else begin
         r_left   = 16'(col_ctr_ff) * 16'(q_ff[0]);
         r_top    = 16'(row_ctr_ff) * 16'(q_ff[1]);
         r_width  = (q_ff[0] != '0) ? 16'(q_ff[0] - QUOT_W'(1)) : 16'd0;
         r_height = (q_ff[1] != '0) ? 16'(q_ff[1] - QUOT_W'(1)) : 16'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      custom_in     = custom_ff;
      tcount_in     = tcount_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      col_ctr_in    = col_ctr_ff;
      row_ctr_in    = row_ctr_ff;
      idx_in        = idx_ff;
      tile_row_in   = tile_row_ff;
      tile_col_in   = tile_col_ff;
      placed_in     = placed_ff;
      prod_in       = prod_ff;
      code_in       = code_ff;
      q0_in         = q0_ff;
      q_in          = q_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_height_in = rsp_height_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && !job_head.is_load) begin
               n_in       = job_head.stream_count;
               custom_in  = cfg.custom_mode && (tcount_sat != 5'd0);
               tcount_in  = tcount_sat;
               cols_in    = (job_head.stream_count <= 5'd9) ? DIV_3 : DIV_4;
               rows_in    = rows_code(job_head.stream_count);
               col_ctr_in = 2'd0;
               row_ctr_in = 2'd0;
               idx_in     = 4'd0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            tile_row_in = tile_rd.grid_row;
            tile_col_in = tile_rd.grid_col;
            placed_in   = !custom_ff || ({1'b0, idx_ff} < tcount_ff);
            if (custom_ff) begin
               prod_in[0] = PROD_W'(tile_rd.left_pct) * PROD_W'(cfg.frame_width);
               prod_in[1] = PROD_W'(tile_rd.top_pct) * PROD_W'(cfg.frame_height);
               prod_in[2] = PROD_W'(tile_rd.width_pct) * PROD_W'(cfg.frame_width);
               prod_in[3] = PROD_W'(tile_rd.height_pct) * PROD_W'(cfg.frame_height);
               code_in[0] = DIV_PCT;
               code_in[1] = DIV_PCT;
               code_in[2] = DIV_PCT;
               code_in[3] = DIV_PCT;
            end else begin
               prod_in[0] = PROD_W'(cfg.frame_width);
               prod_in[1] = PROD_W'(cfg.frame_height);
               prod_in[2] = '0;
               prod_in[3] = '0;
               code_in[0] = cols_ff;
               code_in[1] = rows_ff;
               code_in[2] = DIV_2;
               code_in[3] = DIV_2;
            end
            state_in = ST_RCP;
         end
         ST_RCP: begin
            q0_in    = q0_calc;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            q_in     = q_calc;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register can take the item
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = idx_ff;
               rsp_left_in   = r_left;
               rsp_top_in    = r_top;
               rsp_width_in  = r_width;
               rsp_height_in = r_height;
               rsp_placed_in = placed_ff;
               rsp_last_in   = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 4'd1;
                  if (col_ctr_ff == ((cols_ff == DIV_3) ? 2'd2 : 2'd3)) begin
                     col_ctr_in = 2'd0;
                     row_ctr_in = row_ctr_ff + 2'd1;
                  end else begin
                     col_ctr_in = col_ctr_ff + 2'd1;
                  end
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      custom_ff     <= custom_in;
      tcount_ff     <= tcount_in;
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      col_ctr_ff    <= col_ctr_in;
      row_ctr_ff    <= row_ctr_in;
      idx_ff        <= idx_in;
      tile_row_ff   <= tile_row_in;
      tile_col_ff   <= tile_col_in;
      placed_ff     <= placed_in;
      prod_ff       <= prod_in;
      code_ff       <= code_in;
      q0_ff         <= q0_in;
      q_ff          <= q_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_height_ff <= rsp_height_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_index  = rsp_index_ff;
   assign rsp_rect_left   = rsp_left_ff;
   assign rsp_rect_top    = rsp_top_ff;
   assign rsp_rect_width  = rsp_width_ff;
   assign rsp_rect_height = rsp_height_ff;
   assign rsp_placed      = rsp_placed_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/video_wall_tile_layout_core.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout core
// Places up to sixteen streams on an output frame from a loaded tile table
// or from the built-in one, two, three-four and grid layouts.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  cmd, stream_count, tile slot fields
//   rsp      out  rsp_valid/rsp_stall  one rectangle per stream, last flag
//   csr      in   csr_we               csr_index, csr_wdata
//
// A load item writes its tile slot as the back end pops it; a compose item for
// n streams sends one rectangle per stream, in turn, through the shared four-lane
// divide-by-constant pipeline (table read, scale, reciprocal, fix, output).
// A two-entry queue sits between front and back; req_stall rises when full.
// rsp_stall holds the output register and the back end; the queue fills.
// Reset is synchronous; the tile table is undefined until loaded.
// ----------------------------------------------------------------------------
module video_wall_tile_layout_core #(
   parameter int MAX_STREAMS = 16,
   parameter int MAX_TILES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [4:0]  req_stream_count,
   input  logic [3:0]  req_tile_slot,
   input  logic [6:0]  req_left_pct,
   input  logic [6:0]  req_top_pct,
   input  logic [6:0]  req_width_pct,
   input  logic [6:0]  req_height_pct,
   input  logic [3:0]  req_grid_row,
   input  logic [3:0]  req_grid_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_rect_index,
   output logic [15:0] rsp_rect_left,
   output logic [15:0] rsp_rect_top,
   output logic [15:0] rsp_rect_width,
   output logic [15:0] rsp_rect_height,
   output logic        rsp_placed,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);
   import vwtl_pkg::*;

   localparam int TILE_DEPTH = (MAX_TILES < STREAM_CAP) ? MAX_TILES : STREAM_CAP;
   localparam int TILE_AW    = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

   cfg_type cfg_ff, cfg_in;

   logic               job_valid;
   job_type            job_head;
   logic               job_pop;
   logic               ram_we;
   logic [TILE_AW-1:0] ram_waddr;
   logic [35:0]        ram_wdata;
   logic [TILE_AW-1:0] ram_raddr;
   logic [35:0]        ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata;
            CSR_CUSTOM_MODE:  cfg_in.custom_mode  = csr_wdata[0];
            CSR_TILE_COUNT:   cfg_in.tile_count   = csr_wdata[4:0];
            CSR_SPACING_H:    cfg_in.spacing_h    = csr_wdata[9:0];
            CSR_SPACING_V:    cfg_in.spacing_v    = csr_wdata[9:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= RESET_FRAME_WIDTH;
         cfg_ff.frame_height <= RESET_FRAME_HEIGHT;
         cfg_ff.custom_mode  <= 1'b0;
         cfg_ff.tile_count   <= 5'd0;
         cfg_ff.spacing_h    <= 10'd0;
         cfg_ff.spacing_v    <= 10'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vwtl_front #(
      .MAX_STREAMS (MAX_STREAMS),
      .MAX_TILES   (MAX_TILES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_stream_count (req_stream_count),
      .req_tile_slot    (req_tile_slot),
      .req_left_pct     (req_left_pct),
      .req_top_pct      (req_top_pct),
      .req_width_pct    (req_width_pct),
      .req_height_pct   (req_height_pct),
      .req_grid_row     (req_grid_row),
      .req_grid_col     (req_grid_col),
      .job_valid        (job_valid),
      .job_head         (job_head),
      .job_pop          (job_pop)
   );

   vwtl_ram #(
      .WIDTH (36),
      .DEPTH (TILE_DEPTH)
   ) u_tile_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   vwtl_back #(
      .MAX_TILES  (MAX_TILES),
      .TILE_DEPTH (TILE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .job_valid       (job_valid),
      .job_head        (job_head),
      .job_pop         (job_pop),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rect_index  (rsp_rect_index),
      .rsp_rect_left   (rsp_rect_left),
      .rsp_rect_top    (rsp_rect_top),
      .rsp_rect_width  (rsp_rect_width),
      .rsp_rect_height (rsp_rect_height),
      .rsp_placed      (rsp_placed),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/vwtl_checker.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout: port checker
// Watches the result channel of the core for ordering and content slips.
// ----------------------------------------------------------------------------
`include "video_wall_tile_layout_core_assert.svh"

module vwtl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_rect_index,
   input logic [15:0] rsp_rect_left,
   input logic [15:0] rsp_rect_top,
   input logic [15:0] rsp_rect_width,
   input logic [15:0] rsp_rect_height,
   input logic        rsp_placed,
   input logic        rsp_last
);

   logic [3:0] exp_idx_ff, exp_idx_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // stream index restarts after last, else counts up
   always_comb begin
      exp_idx_in = exp_idx_ff;
      if (rsp_take) begin
         exp_idx_in = rsp_last ? 4'd0 : exp_idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= 4'd0;
      end else begin
         exp_idx_ff <= exp_idx_in;
      end
   end

   `VWTL_ASSERT_RESET(a_reset_clears_rsp, reset, !rsp_valid)

   `VWTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rect_index) && $stable(rsp_rect_left) && $stable(rsp_rect_width) && $stable(rsp_last))

   `VWTL_ASSERT_NOW(a_index_order, rsp_valid, rsp_rect_index == exp_idx_ff)

   `VWTL_ASSERT_NOW(a_unplaced_zero, rsp_valid && !rsp_placed, rsp_rect_left == 16'd0 && rsp_rect_top == 16'd0 && rsp_rect_width == 16'd0 && rsp_rect_height == 16'd0)

endmodule

bind video_wall_tile_layout_core vwtl_checker u_vwtl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_rect_index  (rsp_rect_index),
   .rsp_rect_left   (rsp_rect_left),
   .rsp_rect_top    (rsp_rect_top),
   .rsp_rect_width  (rsp_rect_width),
   .rsp_rect_height (rsp_rect_height),
   .rsp_placed      (rsp_placed),
   .rsp_last        (rsp_last)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Video wall tile layout core testbench
// Sends load and compose items under random sender and receiver idling. A
// local layout calculator predicts every rectangle from mirrored registers
// and a mirrored tile table, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb;
   import vwtl_pkg::*;

   localparam int TILE_SLOTS    = 16;
   localparam int SETTLE_CYCLES = 200;
   localparam int QUIET_LIMIT   = 4000;

   typedef struct {
      logic [3:0]  rect_index;
      logic [15:0] rect_left;
      logic [15:0] rect_top;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic        placed;
      logic        last;
   } rect_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_LOAD;
   logic [4:0]  req_stream_count = '0;
   logic [3:0]  req_tile_slot = '0;
   logic [6:0]  req_left_pct = '0;
   logic [6:0]  req_top_pct = '0;
   logic [6:0]  req_width_pct = '0;
   logic [6:0]  req_height_pct = '0;
   logic [3:0]  req_grid_row = '0;
   logic [3:0]  req_grid_col = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_rect_index;
   logic [15:0] rsp_rect_left;
   logic [15:0] rsp_rect_top;
   logic [15:0] rsp_rect_width;
   logic [15:0] rsp_rect_height;
   logic        rsp_placed;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   cfg_type  layout_cfg = '{frame_width: RESET_FRAME_WIDTH,
                            frame_height: RESET_FRAME_HEIGHT,
                            custom_mode: 1'b0, tile_count: '0,
                            spacing_h: '0, spacing_v: '0};
   tile_type tile_mirror [TILE_SLOTS];
   rect_type expected_rects [$];
   int       errors = 0;
   int       quiet_cycles = 0;
   int       sender_idle_pct = 0;
   int       receiver_idle_pct = 0;

   video_wall_tile_layout_core u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // ---------------------------------------------------------------- predictor
   function automatic int unsigned less_one(int unsigned a);
      return (a > 1) ? a - 1 : 0;
   endfunction

   task automatic push_rect(int unsigned idx, int unsigned l, int unsigned t,
                            int unsigned w, int unsigned h, logic placed, logic last);
      rect_type r;
      r.rect_index  = 4'(idx);
      r.rect_left   = 16'(l);
      r.rect_top    = 16'(t);
      r.rect_width  = 16'(w);
      r.rect_height = 16'(h);
      r.placed      = placed;
      r.last        = last;
      expected_rects.insert(expected_rects.size(), r);
   endtask

   task automatic place_streams();
      int unsigned n, tcount, tw, th, cw, ch, cols, rows, gw, gh, l, t, w, h, i;
      tile_type    tile;
      if (req_cmd == CMD_LOAD) begin
         tile_mirror[req_tile_slot] = '{grid_col: req_grid_col, grid_row: req_grid_row,
                                        height_pct: req_height_pct,
                                        width_pct: req_width_pct,
                                        top_pct: req_top_pct, left_pct: req_left_pct};
         return;
      end
      n      = (req_stream_count > STREAM_CAP) ? STREAM_CAP : req_stream_count;
      tcount = (layout_cfg.tile_count > TILE_SLOTS) ? TILE_SLOTS : layout_cfg.tile_count;
      tw     = layout_cfg.frame_width;
      th     = layout_cfg.frame_height;
      if (n == 0) begin
         return;
      end
      if (layout_cfg.custom_mode && tcount != 0) begin
         for (i = 0; i < n; i++) begin
            if (i < tcount) begin
               tile = tile_mirror[i];
               l = int'(tile.left_pct) * tw / 100;
               t = int'(tile.top_pct) * th / 100;
               w = int'(tile.width_pct) * tw / 100;
               h = int'(tile.height_pct) * th / 100;
               // gaps push the tile along its grid and shrink it, but never to nothing
               if (layout_cfg.spacing_h != 0 || layout_cfg.spacing_v != 0) begin
                  l += int'(tile.grid_col) * layout_cfg.spacing_h;
                  t += int'(tile.grid_row) * layout_cfg.spacing_v;
                  w = (w > layout_cfg.spacing_h) ? w - layout_cfg.spacing_h : 1;
                  h = (h > layout_cfg.spacing_v) ? h - layout_cfg.spacing_v : 1;
               end
               push_rect(i, l, t, w, h, 1'b1, i + 1 == n);
            end else begin
               push_rect(i, 0, 0, 0, 0, 1'b0, i + 1 == n);
            end
         end
      end else if (n == 1) begin
         push_rect(0, 0, 0, tw, th, 1'b1, 1'b1);
      end else if (n <= 4) begin
         cw = less_one(tw / 2);
         ch = less_one(th / 2);
         if (n == 2) begin
            push_rect(0, 0, ch / 2, cw, ch, 1'b1, 1'b0);
            push_rect(1, cw, ch / 2, cw, ch, 1'b1, 1'b1);
         end else begin
            push_rect(0, 0, 0, cw, ch, 1'b1, 1'b0);
            push_rect(1, cw, 0, cw, ch, 1'b1, 1'b0);
            if (n == 3) begin
               push_rect(2, cw / 2, ch, cw, ch, 1'b1, 1'b1);
            end else begin
               push_rect(2, 0, ch, cw, ch, 1'b1, 1'b0);
               push_rect(3, cw, ch, cw, ch, 1'b1, 1'b1);
            end
         end
      end else begin
         cols = (n <= 9) ? 3 : 4;
         rows = (n + cols - 1) / cols;
         gw   = tw / cols;
         gh   = th / rows;
         for (i = 0; i < n; i++) begin
            push_rect(i, (i % cols) * gw, (i / cols) * gh, less_one(gw), less_one(gh),
                      1'b1, i + 1 == n);
         end
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_rect();
      rect_type want;
      if (expected_rects.size() == 0) begin
         $display("%0t: unexpected rectangle, expected none, actual index %0d",
                  $time, rsp_rect_index);
         errors++;
         return;
      end
      want = expected_rects.pop_front();
      compare_field("rect_index", want.rect_index, rsp_rect_index);
      compare_field("rect_left", want.rect_left, rsp_rect_left);
      compare_field("rect_top", want.rect_top, rsp_rect_top);
      compare_field("rect_width", want.rect_width, rsp_rect_width);
      compare_field("rect_height", want.rect_height, rsp_rect_height);
      compare_field("placed", want.placed, rsp_placed);
      compare_field("last", want.last, rsp_last);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  layout_cfg.frame_width  = csr_wdata;
               CSR_FRAME_HEIGHT: layout_cfg.frame_height = csr_wdata;
               CSR_CUSTOM_MODE:  layout_cfg.custom_mode  = csr_wdata[0];
               CSR_TILE_COUNT:   layout_cfg.tile_count   = csr_wdata[4:0];
               CSR_SPACING_H:    layout_cfg.spacing_h    = csr_wdata[9:0];
               CSR_SPACING_V:    layout_cfg.spacing_v    = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            place_streams();
         end
         if (rsp_valid && !rsp_stall) begin
            check_rect();
         end
         if (csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress, %0d rectangles outstanding", $time,
                     expected_rects.size());
            $display("video_wall_tile_layout_core verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   // leaves valid high on return so back-to-back items go out without a gap
   task automatic send_item(logic cmd, logic [4:0] count, logic [3:0] slot,
                            logic [6:0] lp, logic [6:0] tp, logic [6:0] wp,
                            logic [6:0] hp, logic [3:0] row, logic [3:0] col);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 40) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_stream_count <= count;
      req_tile_slot    <= slot;
      req_left_pct     <= lp;
      req_top_pct      <= tp;
      req_width_pct    <= wp;
      req_height_pct   <= hp;
      req_grid_row     <= row;
      req_grid_col     <= col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // unused tile fields carry noise
   task automatic send_compose(int unsigned count);
      send_item(CMD_COMPOSE, 5'(count), 4'($urandom), 7'($urandom), 7'($urandom),
                7'($urandom), 7'($urandom), 4'($urandom), 4'($urandom));
   endtask

   task automatic send_load(int unsigned slot, int unsigned lp, int unsigned tp,
                            int unsigned wp, int unsigned hp, int unsigned row,
                            int unsigned col);
      send_item(CMD_LOAD, 5'($urandom), 4'(slot), 7'(lp), 7'(tp), 7'(wp), 7'(hp),
                4'(row), 4'(col));
   endtask

   function automatic int unsigned random_pct();
      return ($urandom_range(99) < 20) ? $urandom_range(127) : $urandom_range(100);
   endfunction

   function automatic int unsigned random_frame_size();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) begin
         return 16;
      end else if (r < 16) begin
         return 16383;
      end else if (r < 20) begin
         return $urandom_range(15);
      end
      return $urandom_range(16, 16383);
   endfunction

   function automatic int unsigned random_spacing();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 30) begin
         return 0;
      end else if (r < 40) begin
         return 1023;
      end
      return $urandom_range(1023);
   endfunction

   // drop valid, wait out every rectangle, then let trailing loads retire
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_layout_regs(int unsigned w, int unsigned h, int unsigned mode,
                                  int unsigned count, int unsigned sh, int unsigned sv);
      int unsigned vals [6];
      vals = '{w, h, mode, count, sh, sv};
      csr_we <= 1'b1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= 3'(i);
         csr_wdata <= 14'(vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_builtin_layouts();
      int unsigned counts [9] = '{0, 1, 2, 3, 4, 5, 10, 16, 31};
      foreach (counts[i]) begin
         send_compose(counts[i]);
      end
      wait_for_results();
   endtask

   task automatic test_frame_extremes();
      // tiny frame drives cell sizes to zero
      set_layout_regs(3, 1, 0, 0, 0, 0);
      send_compose(2);
      send_compose(7);
      wait_for_results();
      set_layout_regs(16383, 16383, 0, 0, 0, 0);
      send_compose(16);
      wait_for_results();
   endtask

   task automatic test_custom_tiles();
      send_load(0, 127, 127, 127, 127, 15, 15);
      send_load(1, 0, 0, 0, 0, 0, 0);
      send_load(2, 100, 100, 100, 100, $urandom_range(15), $urandom_range(15));
      send_load(3, random_pct(), random_pct(), random_pct(), random_pct(),
                $urandom_range(15), $urandom_range(15));
      wait_for_results();
      // no spacing: zero-size tiles stay zero
      set_layout_regs(1920, 1080, 1, 4, 0, 0);
      send_compose(4);
      wait_for_results();
      // widest gaps, streams past the tile count unplaced
      set_layout_regs(16383, 16383, 1, 3, 1023, 1023);
      send_compose(16);
      wait_for_results();
      // custom with no tiles falls back to built-in
      set_layout_regs(640, 480, 1, 0, 5, 7);
      send_compose(3);
      wait_for_results();
   endtask

   task automatic test_table_fill();
      for (int slot = 0; slot < TILE_SLOTS; slot++) begin
         send_load(slot, random_pct(), random_pct(), random_pct(), random_pct(),
                   $urandom_range(15), $urandom_range(15));
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic(int items, int send_pct, int recv_pct);
      int unsigned count_sel, count;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int k = 0; k < items; k++) begin
         if (k % 24 == 0) begin
            wait_for_results();
            count_sel = $urandom_range(99);
            count = (count_sel < 70) ? $urandom_range(1, 16) : $urandom_range(31);
            set_layout_regs(random_frame_size(), random_frame_size(),
                            ($urandom_range(99) < 60), count,
                            random_spacing(), random_spacing());
         end
         if ($urandom_range(99) < 35) begin
            send_load($urandom_range(15), random_pct(), random_pct(), random_pct(),
                      random_pct(), $urandom_range(15), $urandom_range(15));
         end else if ($urandom_range(99) < 10) begin
            send_compose($urandom_range(31));
         end else begin
            send_compose($urandom_range(1, 16));
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_builtin_layouts();
      test_frame_extremes();
      test_custom_tiles();
      test_table_fill();
      test_random_traffic(66, 31, 79);
      test_random_traffic(66, 79, 31);
      test_random_traffic(66, 0, 0);
      if (errors == 0) begin
         $display("video_wall_tile_layout_core verification clean");
      end else begin
         $display("video_wall_tile_layout_core verification failed");
      end
      $finish;
   end

endmodule
